>>> rtl/wpsdc_pkg.sv
// ----------------------------------------------------------------------------
// wpsdc_pkg
// Shared types, codes and helpers of the wrapping pixel store.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsdc_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_W       = 11;
  localparam int COMP_W      = 16;
  localparam int PIXEL_COMPS = 4;
  localparam int WORD_W      = PIXEL_COMPS * COMP_W;
  localparam int COUNT_W     = 3;
  localparam int BPP_W       = 4;
  localparam int BYTE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Request operations
  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  // Result kinds
  localparam logic RESULT_PIXEL = 1'b0;
  localparam logic RESULT_BYTE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT  = 2'd3;

  // Limits and reset values
  localparam logic [DIM_W-1:0]   DIM_MAX     = 11'd1024;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd128;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [COMP_W-1:0]        put_comp0;
    logic [COMP_W-1:0]        put_comp1;
    logic [COMP_W-1:0]        put_comp2;
    logic [COMP_W-1:0]        put_comp3;
    logic [7:0]               raw_byte;
  } request_t;

  typedef struct packed {
    logic              result_kind;
    logic [COMP_W-1:0] got_comp0;
    logic [COMP_W-1:0] got_comp1;
    logic [COMP_W-1:0] got_comp2;
    logic [COMP_W-1:0] got_comp3;
    logic [7:0]        dump_byte;
    logic              dump_is_final;
  } result_t;

  // Round a 16-bit component to 8 bits: (v + 128) / 257.
  // t / 256 overshoots t / 257 by less than one, so one correction suffices.
  function automatic logic [7:0] round_div257(input logic [COMP_W-1:0] v);
    logic [16:0] t;
    logic [8:0]  q;
    logic [16:0] prod;
    t    = {1'b0, v} + 17'd128;
    q    = t[16:8];
    prod = {q, 8'h00} + {8'h00, q};
    if (prod > t) begin
      q = q - 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/wrapping_pixel_store_depth_convert_top.sv
// ----------------------------------------------------------------------------
// wrapping_pixel_store_depth_convert_top
// Frame store with periodic coordinate wrap and raw byte load and dump.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A get or put wraps its signed
// coordinates through two 12-step dividers and then forms the address with
// one multiply. A load or dump splits its running byte position into pixel
// and byte with a divider of $clog2(MAX_PIXELS*MAX_COMPONENTS*2) steps (17
// at the default size). A result waits in an output register, so the next
// request is taken while it is stalled. The pixel store is a single port RAM
// with registered read data and needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapping_pixel_store_depth_convert_top
  import wpsdc_pkg::*;
#(
  parameter int MAX_PIXELS     = 16384,
  parameter int MAX_COMPONENTS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire request_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output result_t                    out_data,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int POS_W   = $clog2(MAX_PIXELS * MAX_COMPONENTS * 2);
  localparam int TOT_W   = POS_W + 1;
  localparam int RAS_W   = $clog2(MAX_PIXELS + 1);
  localparam int AREA_W  = 2 * DIM_W;
  localparam int AFULL_W = 2 * DIM_W - 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ADDR   = 3'd3;
  localparam logic [2:0] ST_ACCESS = 3'd4;
  localparam logic [2:0] ST_RDATA  = 3'd5;

  // Configuration registers
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [COUNT_W-1:0] component_count;
  logic               sixteen_bit_mode;

  // Control and working state
  logic [2:0]         state;
  logic [2:0]         state_next;
  request_t           req;
  logic [POS_W-1:0]   load_pos;
  logic [POS_W-1:0]   dump_pos;
  logic [POS_W-1:0]   cur_pos;
  logic [WORD_W-1:0]  load_assembly;
  logic [DIM_W-2:0]   xr;
  logic [DIM_W-2:0]   yr;
  logic [AW-1:0]      addr;
  logic               in_range;
  logic               dump_final;
  logic [RAS_W-1:0]   raster;

  // Derived configuration
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [COUNT_W-1:0] comps_eff;
  logic [BPP_W-1:0]   bpp;
  logic [AREA_W-1:0]  area;
  logic [TOT_W-1:0]   ras_ext;
  logic [TOT_W-1:0]   ras_x_comps;
  logic [TOT_W-1:0]   total;

  // Datapath
  logic               is_coord;
  logic [COORD_W-1:0] mag_x;
  logic [COORD_W-1:0] mag_y;
  logic [POS_W-1:0]   pos_sel;
  logic [POS_W-1:0]   pos_wrap;
  logic [TOT_W-1:0]   pos_inc;
  logic [POS_W-1:0]   pos_next;
  logic               div_start_xy;
  logic               div_start_pos;
  logic               x_done;
  logic               y_done;
  logic               p_done;
  logic [COORD_W-1:0] x_quot;
  logic [COORD_W-1:0] y_quot;
  logic [DIM_W-1:0]   x_rem;
  logic [DIM_W-1:0]   y_rem;
  logic [POS_W-1:0]   p_quot;
  logic [BPP_W-1:0]   p_rem;
  logic [DIM_W-1:0]   xr_next;
  logic [DIM_W-1:0]   yr_next;
  logic [AFULL_W-1:0] row_base;
  logic [AFULL_W-1:0] a_full;
  logic [1:0]         comp_idx;
  logic               last_byte;
  logic [WORD_W-1:0]  assembly_next;
  logic [WORD_W-1:0]  asm_base;
  logic [COMP_W-1:0]  dump_comp;
  logic               ram_en;
  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;
  logic               out_free;
  logic               out_load;
  result_t            out_data_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= DIM_RESET;
      image_height     <= DIM_RESET;
      component_count  <= COUNT_RESET;
      sixteen_bit_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width      <= cfg_data;
        REG_IMAGE_HEIGHT: image_height     <= cfg_data;
        REG_COMP_COUNT:   component_count  <= cfg_data[COUNT_W-1:0];
        REG_SIXTEEN_BIT:  sixteen_bit_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal ranges
  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > DIM_MAX) begin
      w_eff = DIM_MAX;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_MAX) begin
      h_eff = DIM_MAX;
    end else begin
      h_eff = image_height;
    end
    if (component_count == '0) begin
      comps_eff = COUNT_W'(1);
    end else if (component_count > COUNT_W'(MAX_COMPONENTS)) begin
      comps_eff = COUNT_W'(MAX_COMPONENTS);
    end else begin
      comps_eff = component_count;
    end
  end

  assign bpp  = sixteen_bit_mode ? {comps_eff, 1'b0} : {1'b0, comps_eff};
  assign area = AREA_W'(w_eff) * AREA_W'(h_eff);

  // Register the raster size, limited to the store
  always_ff @(posedge clk) begin
    raster <= (area > AREA_W'(MAX_PIXELS)) ? RAS_W'(MAX_PIXELS) : area[RAS_W-1:0];
  end

  // Byte count of the raster: pixels times components times bytes
  assign ras_ext = TOT_W'(raster);
  always_comb begin
    case (comps_eff)
      3'd2:    ras_x_comps = ras_ext << 1;
      3'd3:    ras_x_comps = ras_ext + (ras_ext << 1);
      3'd4:    ras_x_comps = ras_ext << 2;
      default: ras_x_comps = ras_ext;
    endcase
  end
  assign total = sixteen_bit_mode ? (ras_x_comps << 1) : ras_x_comps;

  // Operands for the dividers; start only the ones the request needs
  assign is_coord  = (req.operation == OP_GET) || (req.operation == OP_PUT);
  assign mag_x     = req.coord_x[COORD_W-1] ? COORD_W'(~req.coord_x) + COORD_W'(1)
                                            : COORD_W'(req.coord_x);
  assign mag_y     = req.coord_y[COORD_W-1] ? COORD_W'(~req.coord_y) + COORD_W'(1)
                                            : COORD_W'(req.coord_y);
  assign pos_sel   = (req.operation == OP_LOAD) ? load_pos : dump_pos;
  assign pos_wrap  = ({1'b0, pos_sel} >= total) ? '0 : pos_sel;
  assign div_start_xy  = (state == ST_START) && is_coord;
  assign div_start_pos = (state == ST_START) && !is_coord;

  wpsdc_div #(
    .DIVIDEND_W (COORD_W),
    .DIVISOR_W  (DIM_W)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start_xy),
    .dividend  (mag_x),
    .divisor   (w_eff),
    .done      (x_done),
    .quotient  (x_quot),
    .remainder (x_rem)
  );

  wpsdc_div #(
    .DIVIDEND_W (COORD_W),
    .DIVISOR_W  (DIM_W)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start_xy),
    .dividend  (mag_y),
    .divisor   (h_eff),
    .done      (y_done),
    .quotient  (y_quot),
    .remainder (y_rem)
  );

  wpsdc_div #(
    .DIVIDEND_W (POS_W),
    .DIVISOR_W  (BPP_W)
  ) u_div_pos (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start_pos),
    .dividend  (pos_wrap),
    .divisor   (bpp),
    .done      (p_done),
    .quotient  (p_quot),
    .remainder (p_rem)
  );

  // Turn truncated remainders into true modulo
  assign xr_next = (req.coord_x[COORD_W-1] && (x_rem != '0)) ? w_eff - x_rem : x_rem;
  assign yr_next = (req.coord_y[COORD_W-1] && (y_rem != '0)) ? h_eff - y_rem : y_rem;

  // Row-major address of the wrapped coordinates
  assign row_base = AFULL_W'(yr) * AFULL_W'(w_eff);
  assign a_full   = row_base + AFULL_W'(xr);

  // Byte position within the pixel
  assign comp_idx  = sixteen_bit_mode ? p_rem[2:1] : p_rem[1:0];
  assign last_byte = (p_rem == bpp - BPP_W'(1));
  assign pos_inc   = TOT_W'(cur_pos) + TOT_W'(1);
  assign pos_next  = (pos_inc >= total) ? '0 : pos_inc[POS_W-1:0];

  // Merge the loaded byte into the pixel being assembled; a low byte ORs in
  assign asm_base = (p_rem == '0) ? '0 : load_assembly;
  always_comb begin
    assembly_next = asm_base;
    for (int c = 0; c < PIXEL_COMPS; c++) begin
      if (comp_idx == 2'(c)) begin
        if (!sixteen_bit_mode) begin
          assembly_next[c*COMP_W +: COMP_W] = {req.raw_byte, req.raw_byte};
        end else if (!p_rem[0]) begin
          assembly_next[c*COMP_W +: COMP_W] = {req.raw_byte, 8'h00};
        end else begin
          assembly_next[c*COMP_W +: COMP_W] = {asm_base[c*COMP_W+8 +: 8],
                                               asm_base[c*COMP_W +: 8] | req.raw_byte};
        end
      end
    end
  end

  // Sequence one request
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if ((is_coord && x_done) || (!is_coord && p_done)) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_ACCESS;
      ST_ACCESS: begin
        if ((req.operation == OP_GET) || (req.operation == OP_DUMP)) begin
          state_next = ST_RDATA;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Capture the request and intermediate results
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req <= in_data;
    end
    if (state == ST_START) begin
      cur_pos <= pos_wrap;
    end
    if (state == ST_DIV && x_done) begin
      xr <= xr_next[DIM_W-2:0];
      yr <= yr_next[DIM_W-2:0];
    end
    if (state == ST_ADDR) begin
      if (is_coord) begin
        addr     <= a_full[AW-1:0];
        in_range <= a_full < AFULL_W'(MAX_PIXELS);
      end else begin
        addr     <= p_quot[AW-1:0];
        in_range <= p_quot < POS_W'(MAX_PIXELS);
      end
    end
    if (state == ST_ACCESS) begin
      dump_final <= ({1'b0, cur_pos} == total - TOT_W'(1));
    end
  end

  // Advance the running load and dump positions
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos      <= '0;
      dump_pos      <= '0;
      load_assembly <= '0;
    end else if (state == ST_ACCESS) begin
      if (req.operation == OP_LOAD) begin
        load_pos      <= pos_next;
        load_assembly <= assembly_next;
      end else if (req.operation == OP_DUMP) begin
        dump_pos <= pos_next;
      end
    end
  end

  // Pixel store access
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = assembly_next;
    if (state == ST_ACCESS) begin
      case (req.operation)
        OP_PUT: begin
          ram_en    = in_range;
          ram_we    = in_range;
          ram_wdata = {req.put_comp3, req.put_comp2, req.put_comp1, req.put_comp0};
        end
        OP_LOAD: begin
          ram_en = last_byte && in_range;
          ram_we = last_byte && in_range;
        end
        default: ram_en = 1'b1;
      endcase
    end
  end

  wpsdc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PIXELS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Build the result from the read word
  assign dump_comp = ram_rdata[{comp_idx, 4'b0000} +: COMP_W];
  always_comb begin
    out_data_next = '0;
    if (req.operation == OP_GET) begin
      out_data_next.result_kind = RESULT_PIXEL;
      if (in_range) begin
        out_data_next.got_comp0 = ram_rdata[0*COMP_W +: COMP_W];
        out_data_next.got_comp1 = ram_rdata[1*COMP_W +: COMP_W];
        out_data_next.got_comp2 = ram_rdata[2*COMP_W +: COMP_W];
        out_data_next.got_comp3 = ram_rdata[3*COMP_W +: COMP_W];
      end
    end else begin
      out_data_next.result_kind   = RESULT_BYTE;
      out_data_next.dump_is_final = dump_final;
      if (!sixteen_bit_mode) begin
        out_data_next.dump_byte = round_div257(dump_comp);
      end else if (p_rem[0]) begin
        out_data_next.dump_byte = dump_comp[7:0];
      end else begin
        out_data_next.dump_byte = dump_comp[15:8];
      end
    end
  end

  // Hold the result until it is taken
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_RDATA) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  // Coordinate dividers run in lockstep
  assert property (@(posedge clk) disable iff (rst) x_done == y_done)
    else $error("coordinate dividers out of step");

  // Divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    (x_done || p_done) |-> (state == ST_DIV))
    else $error("divider finished outside the wait state");

  // The store is written only by a put or a completed load pixel
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_ACCESS) &&
               ((req.operation == OP_PUT) || (req.operation == OP_LOAD)))
    else $error("unexpected store write");

  // Only get and dump produce a result
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> ((req.operation == OP_GET) || (req.operation == OP_DUMP)))
    else $error("result for a request that has none");

  // An accepted request starts the dividers next
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_START))
    else $error("accepted request did not start");

endmodule

`default_nettype wire

>>> rtl/wpsdc_ram.sv
// ----------------------------------------------------------------------------
// wpsdc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsdc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/wpsdc_div.sv
// ----------------------------------------------------------------------------
// wpsdc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsdc_div #(
  parameter int DIVIDEND_W = 12,
  parameter int DIVISOR_W  = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient,
  output logic      [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     count;
  logic                 busy;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {remainder, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient; results hold until the next start
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= fits ? DIVISOR_W'(trial - {1'b0, dsr}) : trial[DIVISOR_W-1:0];
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> dv/wrapping_pixel_store_depth_convert_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_pixel_store_depth_convert_top_tb
// Self-checking bench for the wrapping pixel store with raw byte load and dump.
// A queued driver sends get, put, load and dump requests with random gaps. An
// in-bench frame store model predicts every pixel read and dumped byte, and a
// monitor with random stalls compares them field by field. The image size,
// component count and byte format change between phases, out-of-range values
// included. The request mix never reads a pixel that was not written.
// ----------------------------------------------------------------------------

module wrapping_pixel_store_depth_convert_top_tb;
  import wpsdc_pkg::*;

  localparam int MAX_PIXELS      = 16384;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 48;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int CALM_START      = 20000;
  localparam int CALM_END        = 30000;

  typedef struct packed {
    logic     drain_first;
    request_t req;
  } queued_request_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  request_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  result_t               out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Frame store model: registers, memory and running byte positions
  logic [DIM_W-1:0]   reg_width  = DIM_RESET;
  logic [DIM_W-1:0]   reg_height = DIM_RESET;
  logic [COUNT_W-1:0] reg_count  = COUNT_RESET;
  logic               reg_wide   = 1'b0;
  bit [WORD_W-1:0]    frame_words [MAX_PIXELS];
  bit [WORD_W-1:0]    load_word   = '0;
  int                 load_cursor = 0;
  int                 dump_cursor = 0;
  result_t            predicted_readback [$];

  // Request planning: which pixels hold data, and where load and dump will be
  bit                 written_map [MAX_PIXELS];
  int                 plan_load_cursor = 0;
  int                 plan_dump_cursor = 0;
  bit                 drain_next       = 1'b0;
  queued_request_t    pending_requests [$];
  int                 planned_items    = 0;
  int                 accepted_count   = 0;

  int                 cycle_count      = 0;
  int                 error_count      = 0;

  wrapping_pixel_store_depth_convert_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Size helpers; zero and oversized register values saturate
  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return int'(DIM_MAX);
    return int'(v);
  endfunction

  function automatic int comp_count();
    if (reg_count == 0) return 1;
    if (reg_count > PIXEL_COMPS) return PIXEL_COMPS;
    return int'(reg_count);
  endfunction

  function automatic int bytes_per_pixel();
    return comp_count() * (reg_wide ? 2 : 1);
  endfunction

  function automatic int raster_bytes();
    int n;
    n = clamp_dim(reg_width) * clamp_dim(reg_height);
    if (n > MAX_PIXELS) n = MAX_PIXELS;
    return n * bytes_per_pixel();
  endfunction

  function automatic int wrap_index(int v, int m);
    int r;
    r = v % m;
    return (r < 0) ? r + m : r;
  endfunction

  // Wrapped address of a coordinate pair, or -1 past the end of the store
  function automatic int frame_address(logic signed [COORD_W-1:0] cx,
                                       logic signed [COORD_W-1:0] cy);
    int w;
    int a;
    w = clamp_dim(reg_width);
    a = wrap_index(int'(cy), clamp_dim(reg_height)) * w + wrap_index(int'(cx), w);
    return (a < MAX_PIXELS) ? a : -1;
  endfunction

  // Advance the model by one accepted request
  function automatic void apply_to_frame_store(request_t r);
    result_t         res;
    int              a;
    int              bpc;
    int              bpp;
    int              total;
    int              pix;
    int              bidx;
    int              comp;
    logic [COMP_W-1:0] v;
    bit [WORD_W-1:0] word;
    bpc   = reg_wide ? 2 : 1;
    bpp   = bytes_per_pixel();
    total = raster_bytes();
    res   = '0;
    case (r.operation)
      OP_GET: begin
        a    = frame_address(r.coord_x, r.coord_y);
        word = (a >= 0) ? frame_words[a] : '0;
        res.result_kind = RESULT_PIXEL;
        {res.got_comp3, res.got_comp2, res.got_comp1, res.got_comp0} = word;
        predicted_readback.push_back(res);
      end
      OP_PUT: begin
        a = frame_address(r.coord_x, r.coord_y);
        if (a >= 0) begin
          frame_words[a] = {r.put_comp3, r.put_comp2, r.put_comp1, r.put_comp0};
        end
      end
      OP_LOAD: begin
        if (load_cursor >= total) load_cursor = 0;
        pix  = load_cursor / bpp;
        bidx = load_cursor % bpp;
        comp = bidx / bpc;
        if (bidx == 0) load_word = '0;
        if (bpc == 1) begin
          load_word[16*comp +: 16] = {r.raw_byte, r.raw_byte};
        end else if (bidx % 2 == 0) begin
          load_word[16*comp +: 16] = {r.raw_byte, 8'h00};
        end else begin
          load_word[16*comp +: 8] = load_word[16*comp +: 8] | r.raw_byte;
        end
        // commit the pixel only on its last byte
        if (bidx == bpp - 1 && pix < MAX_PIXELS) frame_words[pix] = load_word;
        load_cursor++;
        if (load_cursor >= total) load_cursor = 0;
      end
      OP_DUMP: begin
        if (dump_cursor >= total) dump_cursor = 0;
        pix  = dump_cursor / bpp;
        bidx = dump_cursor % bpp;
        comp = bidx / bpc;
        v    = (pix < MAX_PIXELS) ? frame_words[pix][16*comp +: 16] : '0;
        res.result_kind = RESULT_BYTE;
        if (bpc == 1) begin
          res.dump_byte = 8'((int'(v) + 128) / 257);
        end else if (bidx % 2 == 0) begin
          res.dump_byte = v[15:8];
        end else begin
          res.dump_byte = v[7:0];
        end
        res.dump_is_final = (dump_cursor == total - 1);
        dump_cursor++;
        if (dump_cursor >= total) dump_cursor = 0;
        predicted_readback.push_back(res);
      end
    endcase
  endfunction

  // Queue a request and track which pixels it leaves written
  function automatic void queue_request(request_t r);
    queued_request_t q;
    int              a;
    int              bpp;
    int              total;
    bpp   = bytes_per_pixel();
    total = raster_bytes();
    case (r.operation)
      OP_PUT: begin
        a = frame_address(r.coord_x, r.coord_y);
        if (a >= 0) written_map[a] = 1'b1;
      end
      OP_LOAD: begin
        if (plan_load_cursor >= total) plan_load_cursor = 0;
        if (plan_load_cursor % bpp == bpp - 1) written_map[plan_load_cursor / bpp] = 1'b1;
        plan_load_cursor++;
        if (plan_load_cursor >= total) plan_load_cursor = 0;
      end
      OP_DUMP: begin
        if (plan_dump_cursor >= total) plan_dump_cursor = 0;
        plan_dump_cursor++;
        if (plan_dump_cursor >= total) plan_dump_cursor = 0;
      end
      default: begin
      end
    endcase
    q.drain_first = drain_next;
    q.req         = r;
    drain_next    = 1'b0;
    pending_requests.push_back(q);
    planned_items++;
  endfunction

  function automatic request_t random_request(logic [1:0] op);
    request_t r;
    r.operation = op;
    r.coord_x   = 12'($urandom);
    r.coord_y   = 12'($urandom);
    r.put_comp0 = 16'($urandom);
    r.put_comp1 = 16'($urandom);
    r.put_comp2 = 16'($urandom);
    r.put_comp3 = 16'($urandom);
    r.raw_byte  = 8'($urandom);
    return r;
  endfunction

  // Pick a random coordinate that wraps onto base modulo m
  function automatic logic signed [COORD_W-1:0] alias_coord(int base, int m);
    int lo;
    int hi;
    int j;
    lo = -(2048 / m);
    hi = (2047 - base) / m;
    j  = lo + int'($urandom_range(0, hi - lo));
    return 12'(base + m * j);
  endfunction

  function automatic void put_pixel(logic signed [COORD_W-1:0] cx,
                                    logic signed [COORD_W-1:0] cy,
                                    logic [COMP_W-1:0] c0, logic [COMP_W-1:0] c1,
                                    logic [COMP_W-1:0] c2, logic [COMP_W-1:0] c3);
    request_t r;
    r = random_request(OP_PUT);
    r.coord_x   = cx;
    r.coord_y   = cy;
    r.put_comp0 = c0;
    r.put_comp1 = c1;
    r.put_comp2 = c2;
    r.put_comp3 = c3;
    queue_request(r);
  endfunction

  function automatic void load_byte(logic [7:0] b);
    request_t r;
    r = random_request(OP_LOAD);
    r.raw_byte = b;
    queue_request(r);
  endfunction

  // Get a pixel; write it first if it holds nothing yet
  function automatic void add_get(logic signed [COORD_W-1:0] cx,
                                  logic signed [COORD_W-1:0] cy);
    request_t r;
    int       a;
    a = frame_address(cx, cy);
    if (a >= 0 && !written_map[a]) begin
      r = random_request(OP_PUT);
      r.coord_x = cx;
      r.coord_y = cy;
      queue_request(r);
    end
    r = random_request(OP_GET);
    r.coord_x = cx;
    r.coord_y = cy;
    queue_request(r);
  endfunction

  // Dump the next byte; write its pixel first if it holds nothing yet
  function automatic void add_dump();
    request_t r;
    int       total;
    int       pos;
    int       pix;
    int       w;
    total = raster_bytes();
    pos   = (plan_dump_cursor >= total) ? 0 : plan_dump_cursor;
    pix   = pos / bytes_per_pixel();
    if (!written_map[pix]) begin
      w = clamp_dim(reg_width);
      r = random_request(OP_PUT);
      r.coord_x = alias_coord(pix % w, w);
      r.coord_y = alias_coord(pix / w, clamp_dim(reg_height));
      queue_request(r);
    end
    queue_request(random_request(OP_DUMP));
  endfunction

  // Random traffic for one setting: load runs, dump runs, put-get pairs, noise
  function automatic void plan_random_phase(int n);
    int       start;
    int       hold_at;
    bit       hold_done;
    int       kind;
    int       w;
    int       h;
    int       x;
    int       y;
    request_t r;
    start     = planned_items;
    hold_at   = $urandom_range(10, n - 10);
    hold_done = 1'b0;
    w         = clamp_dim(reg_width);
    h         = clamp_dim(reg_height);
    while (planned_items - start < n) begin
      if (!hold_done && planned_items - start >= hold_at) begin
        drain_next = 1'b1;
        hold_done  = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 3 * bytes_per_pixel())) begin
          queue_request(random_request(OP_LOAD));
        end
      end else if (kind < 50) begin
        repeat ($urandom_range(1, 2 * bytes_per_pixel())) add_dump();
      end else if (kind < 75) begin
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
        r = random_request(OP_PUT);
        r.coord_x = alias_coord(x, w);
        r.coord_y = alias_coord(y, h);
        queue_request(r);
        add_get(alias_coord(x, w), alias_coord(y, h));
      end else if (kind < 90) begin
        add_get(12'($urandom), 12'($urandom));
      end else begin
        queue_request(random_request(OP_PUT));
      end
    end
  endfunction

  function automatic bit idle_roll();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  task automatic check_readback(result_t got);
    result_t want;
    if (predicted_readback.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: %h", got));
    end else begin
      want = predicted_readback.pop_front();
      compare_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
      compare_field("got_comp0", got.got_comp0, want.got_comp0);
      compare_field("got_comp1", got.got_comp1, want.got_comp1);
      compare_field("got_comp2", got.got_comp2, want.got_comp2);
      compare_field("got_comp3", got.got_comp3, want.got_comp3);
      compare_field("dump_byte", 16'(got.dump_byte), 16'(want.dump_byte));
      compare_field("dump_is_final", 16'(got.dump_is_final), 16'(want.dump_is_final));
    end
  endtask

  // Wait until every request is taken and every result is back, then settle
  task automatic wait_until_drained();
    while (accepted_count != planned_items || predicted_readback.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  reg_width  = value;
      REG_IMAGE_HEIGHT: reg_height = value;
      REG_COMP_COUNT:   reg_count  = value[COUNT_W-1:0];
      REG_SIXTEEN_BIT:  reg_wide   = value[0];
    endcase
  endtask

  task automatic run_phase(int w, int h, int c, int m);
    wait_until_drained();
    write_register(REG_IMAGE_WIDTH, 11'(w));
    write_register(REG_IMAGE_HEIGHT, 11'(h));
    write_register(REG_COMP_COUNT, 11'(c));
    write_register(REG_SIXTEEN_BIT, 11'(m));
    plan_random_phase(ITEMS_PER_PHASE);
  endtask

  // Driver: retire the accepted request, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_frame_store(in_data);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() == 0 || idle_roll() ||
            (pending_requests[0].drain_first && predicted_readback.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_requests[0].req;
          in_valid <= 1'b1;
          void'(pending_requests.pop_front());
        end
      end
    end
  end

  // Monitor: check each taken result, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_readback(out_data);
      out_stall <= idle_roll();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset settings: 128 x 128, three 8-bit components
    put_pixel(-12'sd2048, -12'sd2048, 16'hffff, 16'h0000, 16'hffff, 16'h0000);
    add_get(12'sd0, 12'sd0);
    put_pixel(12'sd2047, 12'sd2047, 16'h0080, 16'h0181, 16'hffff, 16'h1234);
    add_get(-12'sd1, -12'sd1);
    add_get(12'sd127, -12'sd129);
    // load one full pixel; the unused fourth component reads back as zero
    load_byte(8'h00);
    load_byte(8'hff);
    load_byte(8'h80);
    add_get(12'sd128, 12'sd0);
    // a partly loaded pixel leaves the stored one untouched
    put_pixel(12'sd1, 12'sd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    load_byte(8'h01);
    load_byte(8'hfe);
    add_get(12'sd1, 12'sd0);
    load_byte(8'h07);
    add_get(12'sd1, -12'sd128);
    // dump rounding near half steps and at full scale
    put_pixel(12'sd0, 12'sd0, 16'h0080, 16'h0181, 16'hffff, 16'hffff);
    repeat (6) add_dump();
    plan_random_phase(ITEMS_PER_PHASE);

    // Setting sweep, extremes first
    run_phase(1, 1, 1, 0);
    run_phase(3, 2, 4, 1);
    run_phase(0, 0, 0, 1);
    run_phase(2047, 2047, 7, 1);
    run_phase(1024, 20, 4, 0);
    run_phase(1024, 1, 5, 1);
    run_phase(5, 3, 2, 0);
    run_phase(1, 9, 3, 1);
    repeat (4) begin
      run_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7),
                $urandom_range(0, 1));
    end
    wait_until_drained();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
